[design/iole_pkg.sv]
`default_nettype none
package iole_pkg;

	localparam int CAPACITY = 64;
	localparam int DATA_W   = 32;
	localparam int OP_W     = 4;
	localparam int POS_W    = 7;
	localparam int FPOS_W   = 6;
	localparam int CNT_W    = 7;
	localparam int IDX_W    = $clog2(CAPACITY);

	localparam int IN_BITS  = OP_W + POS_W + DATA_W;
	localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS = 1 + DATA_W + 1 + FPOS_W + CNT_W + 1;
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH_FRONT = 4'd0,
		OP_PUSH_BACK  = 4'd1,
		OP_INSERT     = 4'd2,
		OP_POP_FRONT  = 4'd3,
		OP_POP_BACK   = 4'd4,
		OP_REMOVE     = 4'd5,
		OP_UPDATE     = 4'd6,
		OP_GET        = 4'd7,
		OP_SEARCH     = 4'd8,
		OP_CLEAR      = 4'd9
	} iole_op_t;

	// per-cell command; at most one of the first three is set
	typedef struct packed {
		logic take_left;   // take the lower neighbor's value (open a gap)
		logic take_right;  // take the upper neighbor's value (close a gap)
		logic load;        // take the request value
		logic pick;        // present own value on the read tree
	} iole_cell_ctl_t;

endpackage
`default_nettype wire

[design/iole_cell.sv]
`default_nettype none
module iole_cell (
	input  wire                            clk,
	input  iole_pkg::iole_cell_ctl_t       ctl,
	input  wire  [iole_pkg::DATA_W-1:0]    left_value,
	input  wire  [iole_pkg::DATA_W-1:0]    right_value,
	input  wire  [iole_pkg::DATA_W-1:0]    key,
	output logic [iole_pkg::DATA_W-1:0]    value,
	output logic                           match,
	output logic [iole_pkg::DATA_W-1:0]    pick_value
);
	import iole_pkg::*;

	logic [DATA_W-1:0] value_q;
	logic              match_q;
	logic [DATA_W-1:0] pick_q;

	// payload only, no reset
	always_ff @(posedge clk) begin
		priority if (ctl.take_left) begin
			value_q <= left_value;
		end else if (ctl.take_right) begin
			value_q <= right_value;
		end else if (ctl.load) begin
			value_q <= key;
		end
		// compare and read use the value before this cycle's update
		match_q <= (value_q == key);
		pick_q  <= ctl.pick ? value_q : '0;
	end

	assign value      = value_q;
	assign match      = match_q;
	assign pick_value = pick_q;

endmodule
`default_nettype wire

[design/indexed_ordered_list_engine.sv]
`default_nettype none
// Channel  Dir  Handshake          Payload (tdata, lowest bit first)
// s_axis   in   s_tvalid/s_tready  opcode[3:0] position_in[10:4] value_in[42:11] zero[47:43]
// m_axis   out  m_tvalid/m_tready  ok[0] read_value[32:1] found[33] found_position[39:34]
//                                  count[46:40] is_empty[47]
//
// Every request passes through accept, execute in the cell row (shift, write,
// compare and read in all cells at once), then resolve (first-match encoder and
// read-value OR tree). One request is in flight at a time: a new request is not
// accepted until the current one has left resolve.
// A result waits in the output register; the next request is still accepted
// while it waits, but its resolve step holds until the register is free.
// arst_n clears the count, sequencer and output valid; cell contents are not
// reset and are never read before they are written.
module indexed_ordered_list_engine (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         s_tvalid,
	output logic                        s_tready,
	input  wire  [iole_pkg::IN_W-1:0]   s_tdata,   // opcode, position_in, value_in
	output logic                        m_tvalid,
	input  wire                         m_tready,
	output logic [iole_pkg::OUT_W-1:0]  m_tdata    // ok, read_value, found,
	                                               // found_position, count, is_empty
);
	import iole_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_RESOLVE
	} state_t;

	typedef enum logic [1:0] {
		MODE_NONE,
		MODE_INS,   // open a gap at ep and write there
		MODE_WR,    // write at ep
		MODE_DEL    // close the gap at ep
	} mode_t;

	state_t             state_q;
	logic [OP_W-1:0]    op_q;
	logic [POS_W-1:0]   pos_q;
	logic [DATA_W-1:0]  val_q;
	logic [CNT_W-1:0]   count_q;
	logic               ok_q;
	logic               search_q;
	logic               m_valid_q;
	logic [OUT_W-1:0]   out_data_q;

	// execute-step decode
	logic               ex_ok;
	mode_t              ex_mode;
	logic [POS_W-1:0]   ex_pos;
	logic [CNT_W-1:0]   ex_count;
	logic               ex_get;
	logic               run;

	logic               full;
	logic               empty;
	logic               in_range;
	logic               ins_range;

	iole_cell_ctl_t     cell_ctl   [CAPACITY];
	logic [DATA_W-1:0]  cell_value [CAPACITY];
	logic [DATA_W-1:0]  cell_pick  [CAPACITY];
	logic [CAPACITY-1:0] cell_match;

	// resolve-step signals
	logic [CAPACITY-1:0] live;
	logic [CAPACITY-1:0] hit;
	logic [CAPACITY-1:0] first_hit;
	logic [IDX_W-1:0]    hit_idx;
	logic [DATA_W-1:0]   rd_value;
	logic                found;
	logic [FPOS_W-1:0]   found_pos;
	logic                out_free;

	assign full      = (count_q == CNT_W'(CAPACITY));
	assign empty     = (count_q == '0);
	assign in_range  = (CNT_W'(pos_q) < count_q);
	assign ins_range = (CNT_W'(pos_q) <= count_q);

	always_comb begin
		ex_ok    = 1'b0;
		ex_mode  = MODE_NONE;
		ex_pos   = pos_q;
		ex_count = count_q;
		ex_get   = 1'b0;
		unique case (op_q)
			OP_PUSH_FRONT: begin
				ex_ok   = !full;
				ex_mode = MODE_INS;
				ex_pos  = '0;
				if (ex_ok) ex_count = count_q + 1'b1;
			end
			OP_PUSH_BACK: begin
				ex_ok   = !full;
				ex_mode = MODE_WR;
				ex_pos  = POS_W'(count_q);
				if (ex_ok) ex_count = count_q + 1'b1;
			end
			OP_INSERT: begin
				ex_ok   = !full && ins_range;
				ex_mode = MODE_INS;
				if (ex_ok) ex_count = count_q + 1'b1;
			end
			OP_POP_FRONT: begin
				ex_ok   = !empty;
				ex_mode = MODE_DEL;
				ex_pos  = '0;
				if (ex_ok) ex_count = count_q - 1'b1;
			end
			OP_POP_BACK: begin
				ex_ok = !empty;
				if (ex_ok) ex_count = count_q - 1'b1;
			end
			OP_REMOVE: begin
				ex_ok   = in_range;
				ex_mode = MODE_DEL;
				if (ex_ok) ex_count = count_q - 1'b1;
			end
			OP_UPDATE: begin
				ex_ok   = in_range;
				ex_mode = MODE_WR;
			end
			OP_GET: begin
				ex_ok  = in_range;
				ex_get = in_range;
			end
			OP_SEARCH: begin
				ex_ok = 1'b1;
			end
			OP_CLEAR: begin
				ex_ok    = 1'b1;
				ex_count = '0;
			end
			default: begin
				ex_ok = 1'b0;
			end
		endcase
	end

	assign run = (state_q == ST_EXEC) && ex_ok;

	// the cell row
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DATA_W-1:0] left_v;
		logic [DATA_W-1:0] right_v;

		// a get keeps its cell picked through resolve so a stalled result keeps its value
		always_comb begin
			cell_ctl[i].take_left  = run && (ex_mode == MODE_INS) && (POS_W'(i) > ex_pos);
			cell_ctl[i].take_right = run && (ex_mode == MODE_DEL) && (POS_W'(i) >= ex_pos);
			cell_ctl[i].load       = run && ((ex_mode == MODE_INS) || (ex_mode == MODE_WR))
			                         && (POS_W'(i) == ex_pos);
			cell_ctl[i].pick       = ((state_q == ST_EXEC) || (state_q == ST_RESOLVE))
			                         && ex_get && (POS_W'(i) == pos_q);
		end

		if (i == 0) begin : g_first
			assign left_v = '0;
		end else begin : g_mid_l
			assign left_v = cell_value[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_v = '0;
		end else begin : g_mid_r
			assign right_v = cell_value[i+1];
		end

		iole_cell u_cell (
			.clk         (clk),
			.ctl         (cell_ctl[i]),
			.left_value  (left_v),
			.right_value (right_v),
			.key         (val_q),
			.value       (cell_value[i]),
			.match       (cell_match[i]),
			.pick_value  (cell_pick[i])
		);

		// search never changes the count, so count_q still marks the live cells
		assign live[i] = (CNT_W'(i) < count_q);
	end

	// first match: isolate lowest set bit, then encode the one-hot
	assign hit       = cell_match & live;
	assign first_hit = hit & (~hit + 1'b1);

	always_comb begin
		hit_idx  = '0;
		rd_value = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (first_hit[i]) hit_idx = hit_idx | IDX_W'(i);
			rd_value = rd_value | cell_pick[i];
		end
	end

	assign found     = search_q && (hit != '0);
	assign found_pos = found ? FPOS_W'(hit_idx) : '0;
	assign out_free  = !m_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_RESOLVE) && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					count_q <= ex_count;
					state_q <= ST_RESOLVE;
				end
				ST_RESOLVE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// request and result payload
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_q  <= s_tdata[OP_W-1:0];
			pos_q <= s_tdata[OP_W +: POS_W];
			val_q <= s_tdata[OP_W+POS_W +: DATA_W];
		end
		if (state_q == ST_EXEC) begin
			ok_q     <= ex_ok;
			search_q <= (op_q == OP_SEARCH);
		end
		if ((state_q == ST_RESOLVE) && out_free) begin
			out_data_q <= OUT_W'({(count_q == '0), count_q, found_pos, found, rd_value, ok_q});
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_valid_q;
	assign m_tdata  = out_data_q;

	// count stays within the row
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("count exceeds capacity");

	// an accepted request is executed in the next cycle
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == ST_EXEC))
		else $error("accepted request not executed");

	// resolve with a free output register presents the result next cycle
	a_resolve_out: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_RESOLVE) && out_free) |=> (m_valid_q && (state_q == ST_IDLE)))
		else $error("result not delivered after resolve");

	// a found value implies a successful operation
	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && m_tdata[DATA_W+1]) |-> m_tdata[0])
		else $error("found set without ok");

endmodule
`default_nettype wire

[tb/indexed_ordered_list_engine_tb.sv]
`timescale 1ns / 1ps

module indexed_ordered_list_engine_tb;
	import iole_pkg::*;

	localparam int RANDOM_ITEMS = 1000;
	localparam int MAX_POS      = (1 << POS_W) - 1;
	localparam int MAX_OPCODE   = (1 << OP_W) - 1;

	// request payload as it sits in s_tdata, lowest field at bit 0
	typedef struct packed {
		logic [DATA_W-1:0] value;
		logic [POS_W-1:0]  position;
		logic [OP_W-1:0]   opcode;
	} list_request_t;

	// queued request; hold_until_drained stalls the sender until no result is owed
	typedef struct {
		list_request_t req;
		bit            hold_until_drained;
	} queued_request_t;

	// result payload as it sits in m_tdata, ok at bit 0
	typedef struct packed {
		logic              is_empty;
		logic [CNT_W-1:0]  count;
		logic [FPOS_W-1:0] found_position;
		logic              found;
		logic [DATA_W-1:0] read_value;
		logic              ok;
	} list_result_t;

	logic              clk      = 1'b0;
	logic              arst_n   = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [IN_W-1:0]   s_tdata  = '0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [OUT_W-1:0]  m_tdata;

	queued_request_t   pending_requests[$];
	list_result_t      owed_results[$];

	// shadow of the list contents, updated as each transaction is accepted
	logic [DATA_W-1:0] shadow_list[CAPACITY];
	int unsigned       shadow_len = 0;

	// length as seen by the stimulus generator, used to aim positions in range
	int unsigned       planned_len = 0;
	logic [DATA_W-1:0] value_pool[8];

	int                accepted_items = 0;
	int                total_items    = 0;
	int                sender_idle_pct   = 23;
	int                receiver_idle_pct = 55;
	int                error_count = 0;
	int                result_index = 0;

	indexed_ordered_list_engine i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #5 clk = ~clk;

	task automatic flag_error(input string msg);
		$display("ERROR @%0t: %s", $time, msg);
		error_count++;
	endtask

	task automatic flag_mismatch(input string field, input logic [DATA_W-1:0] want,
			input logic [DATA_W-1:0] seen);
		flag_error($sformatf("result %0d field %s: expected %h, got %h",
			result_index, field, want, seen));
	endtask

	// compute the outcome of one list operation on the shadow list
	task automatic apply_list_op(input list_request_t r, output list_result_t res);
		int unsigned p;
		res = '0;
		p = r.position;
		case (r.opcode)
			OP_PUSH_FRONT: begin
				if (shadow_len < CAPACITY) begin
					for (int i = shadow_len; i > 0; i--)
						shadow_list[i] = shadow_list[i-1];
					shadow_list[0] = r.value;
					shadow_len++;
					res.ok = 1'b1;
				end
			end
			OP_PUSH_BACK: begin
				if (shadow_len < CAPACITY) begin
					shadow_list[shadow_len] = r.value;
					shadow_len++;
					res.ok = 1'b1;
				end
			end
			OP_INSERT: begin
				if (shadow_len < CAPACITY && p <= shadow_len) begin
					for (int i = shadow_len; i > p; i--)
						shadow_list[i] = shadow_list[i-1];
					shadow_list[p] = r.value;
					shadow_len++;
					res.ok = 1'b1;
				end
			end
			OP_POP_FRONT: begin
				if (shadow_len > 0) begin
					for (int i = 0; i + 1 < shadow_len; i++)
						shadow_list[i] = shadow_list[i+1];
					shadow_len--;
					res.ok = 1'b1;
				end
			end
			OP_POP_BACK: begin
				if (shadow_len > 0) begin
					shadow_len--;
					res.ok = 1'b1;
				end
			end
			OP_REMOVE: begin
				if (p < shadow_len) begin
					for (int i = p; i + 1 < shadow_len; i++)
						shadow_list[i] = shadow_list[i+1];
					shadow_len--;
					res.ok = 1'b1;
				end
			end
			OP_UPDATE: begin
				if (p < shadow_len) begin
					shadow_list[p] = r.value;
					res.ok = 1'b1;
				end
			end
			OP_GET: begin
				if (p < shadow_len) begin
					res.read_value = shadow_list[p];
					res.ok = 1'b1;
				end
			end
			OP_SEARCH: begin
				res.ok = 1'b1;
				for (int i = 0; i < shadow_len; i++) begin
					if (!res.found && shadow_list[i] == r.value) begin
						res.found = 1'b1;
						res.found_position = FPOS_W'(i);
					end
				end
			end
			OP_CLEAR: begin
				shadow_len = 0;
				res.ok = 1'b1;
			end
			default: ;  // unknown opcode: nothing changes, ok stays low
		endcase
		res.count    = CNT_W'(shadow_len);
		res.is_empty = (shadow_len == 0);
	endtask

	task automatic add_request(input logic [OP_W-1:0] op, input int unsigned pos,
			input logic [DATA_W-1:0] val, input bit hold = 1'b0);
		queued_request_t q;
		q.req.opcode   = op;
		q.req.position = POS_W'(pos);
		q.req.value    = val;
		q.hold_until_drained = hold;
		pending_requests.push_back(q);
		// follow the length so later positions can be aimed
		case (op)
			OP_PUSH_FRONT, OP_PUSH_BACK: if (planned_len < CAPACITY) planned_len++;
			OP_INSERT: if (planned_len < CAPACITY && pos <= planned_len) planned_len++;
			OP_POP_FRONT, OP_POP_BACK: if (planned_len > 0) planned_len--;
			OP_REMOVE: if (pos < planned_len) planned_len--;
			OP_CLEAR: planned_len = 0;
			default: ;
		endcase
	endtask

	function automatic logic [DATA_W-1:0] pick_value();
		case ($urandom_range(9))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return '0;
			3: return '1;
			4, 5, 6: return value_pool[$urandom_range(7)];
			default: return $urandom;
		endcase
	endfunction

	// mostly in range; the rest anywhere the 7-bit field reaches
	function automatic int unsigned pick_position(input bit for_insert);
		int unsigned top;
		if ($urandom_range(99) < 15)
			return $urandom_range(MAX_POS);
		top = for_insert ? planned_len : (planned_len > 0 ? planned_len - 1 : 0);
		return $urandom_range(top);
	endfunction

	// clear, fill to capacity in a random order, hit the full list, then read back
	task automatic add_fill_burst(input bit hold);
		logic [OP_W-1:0] op;
		add_request(OP_CLEAR, 0, '0, hold);
		for (int i = 0; i < CAPACITY; i++) begin
			op = iole_op_t'(OP_PUSH_FRONT + $urandom_range(2));
			add_request(op, $urandom_range(i), pick_value());
		end
		add_request(OP_PUSH_FRONT, 0, pick_value());
		add_request(OP_PUSH_BACK, 0, pick_value());
		add_request(OP_INSERT, CAPACITY, pick_value());
		add_request(OP_INSERT, $urandom_range(CAPACITY - 1), pick_value());
		add_request(OP_GET, CAPACITY - 1, '0);
		add_request(OP_GET, CAPACITY, '0);
		add_request(OP_UPDATE, CAPACITY - 1, pick_value());
		for (int i = 0; i < 6; i++)
			add_request(OP_SEARCH, 0, pick_value());
	endtask

	task automatic add_mixed_request();
		int r;
		int grow;
		logic [OP_W-1:0] op;
		// keep the depth moving over the whole range
		grow = (planned_len < 8) ? 50 : (planned_len > CAPACITY - 8) ? 20 : 35;
		r = $urandom_range(99);
		if (r < grow) begin
			op = iole_op_t'(OP_PUSH_FRONT + $urandom_range(2));
			add_request(op, pick_position(1'b1), pick_value());
		end else if (r < grow + 20) begin
			op = iole_op_t'(OP_POP_FRONT + $urandom_range(2));
			add_request(op, pick_position(1'b0), pick_value());
		end else if (r < grow + 35) begin
			add_request(OP_UPDATE, pick_position(1'b0), pick_value());
		end else if (r < grow + 45) begin
			add_request(OP_SEARCH, $urandom_range(MAX_POS), pick_value());
		end else if (r < 96) begin
			add_request(OP_GET, pick_position(1'b0), $urandom);
		end else if (r < 97) begin
			add_request(OP_CLEAR, $urandom_range(MAX_POS), $urandom);
		end else begin
			add_request(OP_W'($urandom_range(MAX_OPCODE, OP_CLEAR + 1)),
				$urandom_range(MAX_POS), $urandom);
		end
	endtask

	// driver: presents queued requests, holds each until accepted
	always @(posedge clk) begin
		queued_request_t taken;
		list_result_t    predicted;
		bit              present;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				taken = pending_requests.pop_front();
				apply_list_op(taken.req, predicted);
				owed_results.push_back(predicted);
				accepted_items++;
				// idle mix changes at each third of the run
				if (accepted_items == total_items / 3) begin
					sender_idle_pct   = 55;
					receiver_idle_pct = 23;
				end else if (accepted_items == 2 * total_items / 3) begin
					sender_idle_pct   = 0;
					receiver_idle_pct = 0;
				end
			end
			if (s_tvalid && !s_tready)
				present = 1'b1;
			else
				present = pending_requests.size() != 0
					&& !(pending_requests[0].hold_until_drained && owed_results.size() != 0)
					&& $urandom_range(99) >= sender_idle_pct;
			s_tvalid <= present;
			if (present)
				s_tdata <= {{(IN_W - $bits(list_request_t)){1'b0}}, pending_requests[0].req};
		end
	end

	// monitor: takes each result transaction and checks it against the oldest prediction
	always @(posedge clk) begin
		list_result_t seen;
		list_result_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				seen = m_tdata;
				if (owed_results.size() == 0) begin
					flag_error($sformatf("unexpected result %h", m_tdata));
				end else begin
					want = owed_results.pop_front();
					if (seen.ok !== want.ok)
						flag_mismatch("ok", want.ok, seen.ok);
					if (seen.read_value !== want.read_value)
						flag_mismatch("read_value", want.read_value, seen.read_value);
					if (seen.found !== want.found)
						flag_mismatch("found", want.found, seen.found);
					if (seen.found_position !== want.found_position)
						flag_mismatch("found_position", want.found_position,
							seen.found_position);
					if (seen.count !== want.count)
						flag_mismatch("count", want.count, seen.count);
					if (seen.is_empty !== want.is_empty)
						flag_mismatch("is_empty", want.is_empty, seen.is_empty);
				end
				result_index++;
			end
			m_tready <= $urandom_range(99) >= receiver_idle_pct;
		end
	end

	initial begin
		for (int i = 0; i < 8; i++)
			value_pool[i] = $urandom;

		// directed: empty list corners, extremes, duplicates, out-of-range positions
		add_request(OP_SEARCH, 0, '0);
		add_request(OP_POP_FRONT, 0, '0);
		add_request(OP_POP_BACK, 0, '0);
		add_request(OP_GET, 0, '0);
		add_request(OP_REMOVE, 0, '0);
		add_request(OP_UPDATE, 0, 32'h1234_5678);
		add_request(OP_INSERT, 1, 32'h1234_5678);
		add_request(OP_INSERT, 0, 32'h7fff_ffff);
		add_request(OP_PUSH_FRONT, 0, 32'h8000_0000);
		add_request(OP_PUSH_BACK, 0, '1);
		add_request(OP_PUSH_BACK, 0, '0);
		add_request(OP_INSERT, 4, 32'h8000_0000);
		add_request(OP_GET, 0, '0);
		add_request(OP_GET, 3, '0);
		add_request(OP_GET, MAX_POS, '0);
		add_request(OP_SEARCH, 0, 32'h8000_0000);
		add_request(OP_SEARCH, 0, 32'h0000_3039);
		add_request(OP_UPDATE, 2, 32'h5555_5555);
		add_request(OP_UPDATE, 5, 32'haaaa_aaaa);
		add_request(OP_REMOVE, 1, '0);
		add_request(OP_REMOVE, CAPACITY, '0);
		add_request(OP_W'(OP_CLEAR + 1), 3, '1);
		add_request(OP_W'(MAX_OPCODE), MAX_POS, '1);
		add_request(OP_INSERT, MAX_POS, '1);
		add_request(OP_CLEAR, 0, '0);
		add_request(OP_SEARCH, 0, '0);

		// random: one fill burst per idle phase, each started from a drained block
		for (int seg = 0; seg < 3; seg++) begin
			add_fill_burst(1'b1);
			for (int i = 0; i < RANDOM_ITEMS / 3 - 80; i++)
				add_mixed_request();
		end
		total_items = pending_requests.size();

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_requests.size() != 0 || s_tvalid)
			@(posedge clk);
		while (owed_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		if (error_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#3_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
